>>> rtl/clipped_rect_fill_top_defines.svh
// Assertion macros for the clipped rectangle fill engine.
`ifndef CLIPPED_RECT_FILL_TOP_DEFINES_SVH
`define CLIPPED_RECT_FILL_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define CRF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication into the next cycle.
`define CRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/crf_pkg.sv
// Shared constants and codes of the clipped rectangle fill engine.
package crf_pkg;

  localparam int STORE_DEPTH  = 65536;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int SCREEN_LIMIT = 4096;
  localparam int DIM_W        = 13;
  localparam int COORD_W      = 16;
  localparam int COLOR_W      = 32;
  localparam int COUNT_W      = 17;
  localparam int STATUS_W     = 2;
  localparam int RDADDR_W     = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int AREA_W       = 2 * DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd256;

  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DREW    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_READ_OK = 2'd2;

endpackage

>>> rtl/crf_req_if.sv
// Request channel of the fill engine: valid/ready handshake with fill or read payload.
interface crf_req_if;
  import crf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic signed [COORD_W-1:0]  rect_x;
  logic signed [COORD_W-1:0]  rect_y;
  logic signed [COORD_W-1:0]  rect_w;
  logic signed [COORD_W-1:0]  rect_h;
  logic [COLOR_W-1:0]         fill_color;
  logic [RDADDR_W-1:0]        read_address;

  modport source (
    output valid, req_type, rect_x, rect_y, rect_w, rect_h, fill_color, read_address,
    input  ready
  );
  modport sink (
    input  valid, req_type, rect_x, rect_y, rect_w, rect_h, fill_color, read_address,
    output ready
  );
endinterface

>>> rtl/crf_rsp_if.sv
// Result channel of the fill engine: valid/ready handshake with status, count and data.
interface crf_rsp_if;
  import crf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   pixels_written;
  logic [COLOR_W-1:0]   read_data;

  modport source (output valid, status, pixels_written, read_data, input ready);
  modport sink   (input valid, status, pixels_written, read_data, output ready);
endinterface

>>> rtl/crf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/clipped_rect_fill_top.sv
// Top level of the clipped rectangle fill engine.
// A fill request clips x,y,w,h to the screen set by screen_width/screen_height
// and writes fill_color to each covered pixel at row*width+col of a
// 65536-word frame store, one pixel per cycle; the result carries the
// pixel count and status. A read request returns one stored pixel. The block
// takes one request at a time. Setup steps share one 13x13 multiplier for
// the screen area and the first row base; then the single RAM write port
// sets the pace. A finished result waits while the output register still
// holds the previous one. A finished result sits in an output register,
// so the next request is accepted while it waits. Screens of zero size,
// above 4096 or larger than the store draw nothing. Pixels never written
// read back undefined.
`include "clipped_rect_fill_top_defines.svh"

module clipped_rect_fill_top (
  input  logic                           clk,
  input  logic                           rst_n,
  crf_req_if.sink                        in_req,
  crf_rsp_if.source                      out_rsp,
  input  logic                           cfg_we,
  input  logic [crf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crf_pkg::DIM_W-1:0]      cfg_wdata
);
  import crf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_AREA, ST_CLIP, ST_BASE, ST_FILL, ST_READ, ST_RWAIT, ST_DONE
  } state_t;

  state_t state_r;

  logic [DIM_W-1:0]          width_r, height_r;
  logic                      type_r;
  logic signed [COORD_W-1:0] x_r, y_r, w_r, h_r;
  logic [COLOR_W-1:0]        color_r;
  logic [RDADDR_W-1:0]       rdaddr_r;
  logic [AREA_W-1:0]         area_r;
  logic [DIM_W-1:0]          left_r, right_r, top_r, bottom_r;
  logic [DIM_W-1:0]          col_r, row_r;
  logic [ADDR_W-1:0]         base_r;
  logic [COUNT_W-1:0]        count_r;
  logic                      drew_r;
  logic [COLOR_W-1:0]        data_r;
  logic                      rd_ok_r;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic [COLOR_W-1:0]        out_data_r;

  // shared multiplier
  logic [DIM_W-1:0]  mul_a, mul_b;
  logic [AREA_W-1:0] product;

  assign mul_a   = (state_r == ST_AREA) ? width_r  : top_r;
  assign mul_b   = (state_r == ST_AREA) ? height_r : width_r;
  assign product = AREA_W'(mul_a) * AREA_W'(mul_b);

  // clipping
  localparam int CW = COORD_W + 2;
  logic signed [CW-1:0] xe, ye, we_s, he_s, xr, yb, wd, hd;
  logic signed [CW-1:0] left_c, top_c, right_c, bottom_c;
  logic                 screen_ok, rect_ok, clip_ok;

  always_comb begin
    xe       = CW'(x_r);
    ye       = CW'(y_r);
    we_s     = CW'(w_r);
    he_s     = CW'(h_r);
    xr       = xe + we_s;
    yb       = ye + he_s;
    wd       = signed'(CW'(width_r));
    hd       = signed'(CW'(height_r));
    left_c   = x_r[COORD_W-1] ? '0 : xe;
    top_c    = y_r[COORD_W-1] ? '0 : ye;
    right_c  = (xr < wd) ? xr : wd;
    bottom_c = (yb < hd) ? yb : hd;
    screen_ok = (width_r != '0) && (height_r != '0)
             && (32'(width_r) <= 32'(SCREEN_LIMIT))
             && (32'(height_r) <= 32'(SCREEN_LIMIT))
             && (32'(area_r) <= 32'(STORE_DEPTH));
    rect_ok  = !w_r[COORD_W-1] && (w_r != '0) && !h_r[COORD_W-1] && (h_r != '0);
    clip_ok  = (left_c < right_c) && (top_c < bottom_c);
  end

  // fill stepping
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic [ADDR_W-1:0] wr_addr;
  logic              row_end, last_px;

  assign col_inc = col_r + DIM_W'(1);
  assign row_inc = row_r + DIM_W'(1);
  assign wr_addr = base_r + ADDR_W'(col_r);
  assign row_end = (col_inc == right_r);
  assign last_px = row_end && (row_inc == bottom_r);

  logic [COLOR_W-1:0] ram_rdata;
  logic               ram_we;

  assign ram_we = (state_r == ST_FILL);

  crf_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (color_r),
    .raddr (ADDR_W'(rdaddr_r)),
    .rdata (ram_rdata)
  );

  logic in_fire, out_free;
  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
          REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            type_r   <= in_req.req_type;
            x_r      <= in_req.rect_x;
            y_r      <= in_req.rect_y;
            w_r      <= in_req.rect_w;
            h_r      <= in_req.rect_h;
            color_r  <= in_req.fill_color;
            rdaddr_r <= in_req.read_address;
            count_r  <= '0;
            drew_r   <= 1'b0;
            data_r   <= '0;
            rd_ok_r  <= 1'b0;
            state_r  <= (in_req.req_type == REQ_READ) ? ST_READ : ST_AREA;
          end
        end
        ST_AREA: begin
          area_r  <= product;
          state_r <= ST_CLIP;
        end
        ST_CLIP: begin
          left_r   <= DIM_W'(left_c);
          right_r  <= DIM_W'(right_c);
          top_r    <= DIM_W'(top_c);
          bottom_r <= DIM_W'(bottom_c);
          col_r    <= DIM_W'(left_c);
          row_r    <= DIM_W'(top_c);
          state_r  <= (screen_ok && rect_ok && clip_ok) ? ST_BASE : ST_DONE;
        end
        ST_BASE: begin
          base_r  <= ADDR_W'(product);
          drew_r  <= 1'b1;
          state_r <= ST_FILL;
        end
        ST_FILL: begin
          count_r <= count_r + COUNT_W'(1);
          if (row_end) begin
            col_r  <= left_r;
            row_r  <= row_inc;
            base_r <= base_r + ADDR_W'(width_r);
          end else begin
            col_r <= col_inc;
          end
          if (last_px) begin
            state_r <= ST_DONE;
          end
        end
        ST_READ: begin
          state_r <= ST_RWAIT;
        end
        ST_RWAIT: begin
          if (32'(rdaddr_r) < 32'(STORE_DEPTH)) begin
            data_r  <= ram_rdata;
            rd_ok_r <= 1'b1;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_count_r <= count_r;
            out_data_r  <= data_r;
            if (type_r == REQ_READ) begin
              out_status_r <= rd_ok_r ? STATUS_READ_OK : STATUS_NONE;
            end else begin
              out_status_r <= drew_r ? STATUS_DREW : STATUS_NONE;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_req.ready           = (state_r == ST_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.pixels_written = out_count_r;
  assign out_rsp.read_data      = out_data_r;

  `CRF_ASSERT_ALWAYS(a_fill_in_bounds,
      (state_r != ST_FILL) || ((col_r < right_r) && (row_r < bottom_r)),
      "fill position outside clipped rectangle")
  `CRF_ASSERT_ALWAYS(a_read_no_count,
      !(out_rsp.valid && (out_rsp.status == STATUS_READ_OK)) || (out_rsp.pixels_written == '0),
      "read result carries a pixel count")
  `CRF_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_req.ready,
      "request accepted while previous one still in progress")
  `CRF_ASSERT_ALWAYS(a_write_in_store,
      !ram_we || (32'(wr_addr) < 32'(area_r)),
      "frame store write beyond screen area")
endmodule

>>> tb/sv/clipped_rect_fill_checker.sv
// Scoreboard for the fill engine: shadow frame store, result prediction and comparison.
module clipped_rect_fill_checker
  import crf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  crf_req_if                   req_mon,
  crf_rsp_if                   rsp_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  pixels_written;
    logic [COLOR_W-1:0]  read_data;
  } rsp_fields_t;

  bit [COLOR_W-1:0] shadow_pixels [STORE_DEPTH];
  logic [DIM_W-1:0] scr_w;
  logic [DIM_W-1:0] scr_h;
  rsp_fields_t      owed_rsp_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Clip to the screen, paint the shadow store, give the pixel count.
  function automatic rsp_fields_t paint_rect(input int x, input int y, input int w,
                                             input int h, input logic [COLOR_W-1:0] color);
    rsp_fields_t r;
    int          sw;
    int          sh;
    int          col_lo;
    int          col_hi;
    int          row_lo;
    int          row_hi;
    int          addr;
    int unsigned count;
    r        = '0;
    r.status = STATUS_NONE;
    count    = 0;
    sw       = int'(scr_w);
    sh       = int'(scr_h);
    if (sw == 0 || sh == 0 || sw > SCREEN_LIMIT || sh > SCREEN_LIMIT) return r;
    if (sw * sh > STORE_DEPTH) return r;
    if (w <= 0 || h <= 0) return r;
    col_lo = (x < 0) ? 0 : x;
    row_lo = (y < 0) ? 0 : y;
    col_hi = x + w;
    row_hi = y + h;
    if (col_hi > sw) col_hi = sw;
    if (row_hi > sh) row_hi = sh;
    if (col_lo >= col_hi || row_lo >= row_hi) return r;
    for (int row = row_lo; row < row_hi; row++) begin
      for (int col = col_lo; col < col_hi; col++) begin
        addr = row * sw + col;
        if (addr < STORE_DEPTH) begin
          shadow_pixels[addr] = color;
          count++;
        end
      end
    end
    r.pixels_written = count[COUNT_W-1:0];
    r.status         = (count != 0) ? STATUS_DREW : STATUS_NONE;
    return r;
  endfunction

  function automatic rsp_fields_t look_up_pixel(input logic [RDADDR_W-1:0] addr);
    rsp_fields_t r;
    r        = '0;
    r.status = STATUS_NONE;
    if (int'(addr) < STORE_DEPTH) begin
      r.status    = STATUS_READ_OK;
      r.read_data = shadow_pixels[addr];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_fields_t want;
    if (!rst_n) begin
      scr_w = WIDTH_RESET;
      scr_h = HEIGHT_RESET;
      owed_rsp_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w = cfg_wdata;
          REG_SCREEN_HEIGHT: scr_h = cfg_wdata;
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("result with no request", 32'(rsp_mon.status), '0);
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_mon.status !== want.status)
            report_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
          if (rsp_mon.pixels_written !== want.pixels_written)
            report_mismatch("pixels_written", 32'(rsp_mon.pixels_written),
                            32'(want.pixels_written));
          if (rsp_mon.read_data !== want.read_data)
            report_mismatch("read_data", rsp_mon.read_data, want.read_data);
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == REQ_FILL) begin
          owed_rsp_q.push_back(paint_rect($signed(req_mon.rect_x), $signed(req_mon.rect_y),
                                          $signed(req_mon.rect_w), $signed(req_mon.rect_h),
                                          req_mon.fill_color));
        end else begin
          owed_rsp_q.push_back(look_up_pixel(req_mon.read_address));
        end
      end
      outstanding <= owed_rsp_q.size();
    end
  end

endmodule

>>> tb/sv/clipped_rect_fill_top_tb.sv
// Testbench top for the fill engine: clock, reset, request stimulus, screen setup and verdict.
module clipped_rect_fill_top_tb;
  import crf_pkg::*;

  localparam int WATCHDOG_LIMIT  = 262144;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 9;
  localparam int NUM_PHASES      = 13;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int PHASE_W [NUM_PHASES] = '{64, 1, 4096, 16, 13, 4096, 0, 8191, 4097, 300,
                                          4096, 256, 100};
  localparam int PHASE_H [NUM_PHASES] = '{64, 1, 16, 4096, 37, 4096, 200, 1, 8, 300,
                                          1, 256, 50};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   outstanding;
  bit                   sender_idles;
  bit                   receiver_stalls;
  bit                   hold_off_due;
  int                   last_x;
  int                   last_y;

  crf_req_if req_ch ();
  crf_rsp_if rsp_ch ();

  clipped_rect_fill_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_ch),
    .out_rsp   (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  clipped_rect_fill_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_req(input logic kind, input int x, input int y, input int w,
                          input int h, input logic [COLOR_W-1:0] color,
                          input logic [RDADDR_W-1:0] addr);
    while (sender_idles && $urandom_range(99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.rect_x       <= x[COORD_W-1:0];
    req_ch.rect_y       <= y[COORD_W-1:0];
    req_ch.rect_w       <= w[COORD_W-1:0];
    req_ch.rect_h       <= h[COORD_W-1:0];
    req_ch.fill_color   <= color;
    req_ch.read_address <= addr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == REQ_FILL) begin
      last_x = x;
      last_y = y;
    end
  endtask

  task automatic fill_rect(input int x, input int y, input int w, input int h,
                           input logic [COLOR_W-1:0] color);
    send_req(REQ_FILL, x, y, w, h, color, RDADDR_W'($urandom));
  endtask

  // rectangle fields carry junk on reads
  task automatic read_pixel(input logic [RDADDR_W-1:0] addr);
    send_req(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, addr);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_wdata <= DIM_W'(w);
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_wdata <= DIM_W'(h);
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_wdata <= DIM_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item(input int sw, input int sh, input bit noise_ok);
    int pick;
    int row;
    int col;
    int x;
    int y;
    int w;
    int h;
    pick = $urandom_range(99);
    if (pick < 34) begin
      if ($urandom_range(1)) begin
        // land near the last fill
        row = last_y + int'($urandom_range(6));
        col = last_x + int'($urandom_range(6));
        if (row >= sh) row = sh - 1;
        if (col >= sw) col = sw - 1;
        if (row < 0) row = 0;
        if (col < 0) col = 0;
        read_pixel(RDADDR_W'(row * sw + col));
      end else begin
        read_pixel(RDADDR_W'($urandom));
      end
    end else if (pick < 42 && noise_ok) begin
      fill_rect($urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      x = int'($urandom_range(sw + 8)) - 6;
      y = int'($urandom_range(sh + 8)) - 6;
      w = int'($urandom_range(30)) - 3;
      h = int'($urandom_range(30)) - 3;
      fill_rect(x, y, w, h, $urandom);
    end
  endtask

  initial begin : result_sink
    int held;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        rsp_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end else begin
        rsp_ch.ready <= !receiver_stalls || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("clipped_rect_fill_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int area;
    bit noise_ok;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_SCREEN_WIDTH;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_FILL;
    req_ch.rect_x       = '0;
    req_ch.rect_y       = '0;
    req_ch.rect_w       = '0;
    req_ch.rect_h       = '0;
    req_ch.fill_color   = '0;
    req_ch.read_address = '0;
    sender_idles        = 1'b1;
    receiver_stalls     = 1'b1;
    hold_off_due        = 1'b0;
    last_x              = 0;
    last_y              = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // whole store painted first, so every later read hits a written pixel
    fill_rect(0, 0, 256, 256, 32'hA5A5_5A5A);
    read_pixel(16'h0000);
    read_pixel(16'hFFFF);
    fill_rect(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF);
    fill_rect(32767, 32767, 32767, 32767, 32'h0000_0000);
    fill_rect(10, 10, 0, 5, $urandom);
    fill_rect(10, 10, 5, -32768, $urandom);
    fill_rect(10, 10, -1, -1, $urandom);
    fill_rect(-5, -3, 10, 8, 32'h0000_0000);
    read_pixel(16'h0000);
    read_pixel(RDADDR_W'(4 * 256 + 4));
    read_pixel(RDADDR_W'(4 * 256 + 5));
    fill_rect(250, 252, 20, 20, 32'hFFFF_FFFF);
    read_pixel(RDADDR_W'(252 * 256 + 250));
    read_pixel(RDADDR_W'(251 * 256 + 250));
    fill_rect(255, 255, 1, 1, $urandom);
    read_pixel(16'hFFFF);
    fill_rect(256, 0, 4, 4, $urandom);
    fill_rect(0, 256, 4, 4, $urandom);
    fill_rect(-100, 100, 32767, 1, $urandom);
    read_pixel(RDADDR_W'(100 * 256 + 17));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_screen(PHASE_W[p], PHASE_H[p]);
      sender_idles    = (p != 0);
      receiver_stalls = (p != 0);
      if (p == NUM_PHASES - 1) hold_off_due = 1'b1;
      area     = PHASE_W[p] * PHASE_H[p];
      noise_ok = (area <= 4096) || (area > STORE_DEPTH) ||
                 (PHASE_W[p] > SCREEN_LIMIT) || (PHASE_H[p] > SCREEN_LIMIT);
      repeat (ITEMS_PER_PHASE) random_item(PHASE_W[p], PHASE_H[p], noise_ok);
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("clipped_rect_fill_top regression: pass");
    end else begin
      $display("clipped_rect_fill_top regression: fail");
    end
    $finish;
  end

endmodule
